// ===== src/lda_pkg.sv =====
// shared types, operation and status codes for the log-domain arithmetic unit
// also holds the elaboration-time series used to fill the correction tables
`default_nettype none

package lda_pkg;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_SUB_BIG = 2'd1,
		ST_DIV_Z   = 2'd2,
		ST_SAT     = 2'd3
	} status_t;

	localparam int LOG_W = 32;

	localparam logic signed [LOG_W-1:0] LOG_MAX = {1'b0, {(LOG_W-1){1'b1}}};
	localparam logic signed [LOG_W-1:0] LOG_MIN = {1'b1, {(LOG_W-1){1'b0}}};

	// operands and their compare results, carried down the pipe
	typedef struct packed {
		cmd_t                     cmd;
		logic                     az;
		logic                     bz;
		logic signed [LOG_W-1:0]  a;
		logic signed [LOG_W-1:0]  b;
		logic                     a_gt_b;
		logic                     a_eq_b;
		logic        [LOG_W-1:0]  d;
		logic signed [LOG_W-1:0]  m;
		logic signed [LOG_W:0]    sum;
		logic signed [LOG_W:0]    dif;
	} front_t;

	localparam logic [63:0] Q30_ONE = 64'd1 << 30;

	// shift-subtract divide, elaboration only
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// 2*atanh(z), z in q30
	function automatic logic [63:0] twice_atanh(input logic [63:0] z);
		logic [63:0] z2;
		logic [63:0] p;
		logic [63:0] acc;
		logic [63:0] n;
		z2  = (z * z) >> 30;
		p   = z;
		acc = '0;
		n   = 64'd1;
		while (p != 0 && n < 64'd400) begin
			acc = acc + udiv64(p, n);
			p   = (p * z2) >> 30;
			n   = n + 64'd2;
		end
		return acc << 1;
	endfunction

	// exp(-f), f in q30, 0 <= f <= 1
	function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
		logic signed [63:0] acc;
		logic [63:0] t;
		logic [63:0] n;
		acc = $signed(Q30_ONE);
		t   = Q30_ONE;
		n   = 64'd1;
		while (t != 0 && n < 64'd64) begin
			t = udiv64((t * f) >> 30, n);
			if (n[0])
				acc = acc - $signed(t);
			else
				acc = acc + $signed(t);
			n = n + 64'd1;
		end
		return (acc < 0) ? 64'd0 : acc;
	endfunction

	// exp(-x), x in q30 below 16, e1 = exp(-1) in q30
	function automatic logic [63:0] exp_neg(input logic [63:0] x, input logic [63:0] e1);
		logic [63:0] r;
		logic [63:0] k;
		r = exp_neg_frac(x & (Q30_ONE - 64'd1));
		k = x >> 30;
		while (k > 0) begin
			r = (r * e1) >> 30;
			k = k - 64'd1;
		end
		return r;
	endfunction

	// ln(w), w in q30, 0 < w <= 2
	function automatic logic signed [63:0] ln_q30(input logic [63:0] w_in,
		input logic [63:0] ln2);
		logic [63:0] w;
		logic signed [63:0] k;
		logic signed [63:0] res;
		w = (w_in == 0) ? 64'd1 : w_in;
		k = '0;
		while (w < (Q30_ONE >> 1)) begin
			w = w << 1;
			k = k + 64'sd1;
		end
		if (w >= Q30_ONE)
			res = $signed(twice_atanh(udiv64((w - Q30_ONE) << 30, w + Q30_ONE)));
		else
			res = -$signed(twice_atanh(udiv64((Q30_ONE - w) << 30, Q30_ONE + w)));
		return res - k * $signed(ln2);
	endfunction

	// q30 to fb fraction bits, round half away from zero
	function automatic logic signed [63:0] to_frac(input logic signed [63:0] v,
		input int fb);
		logic [63:0] half;
		logic [63:0] mag;
		half = 64'd1 << (30 - fb - 1);
		if (v >= 0)
			return $signed((v + half) >> (30 - fb));
		mag = -v;
		return -$signed((mag + half) >> (30 - fb));
	endfunction

endpackage

`default_nettype wire

// ===== src/lda_front.sv =====
// stage one: register the beat with its compare, difference, sum and max
// depends on lda_pkg
`default_nettype none

module lda_front
	import lda_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_vld,
	input  wire cmd_t                    cmd,
	input  wire logic signed [LOG_W-1:0] a_log,
	input  wire logic                    a_zero,
	input  wire logic signed [LOG_W-1:0] b_log,
	input  wire logic                    b_zero,
	output logic                         vld_s1,
	output front_t                       f_s1
);

	front_t f_d;

	always_comb begin
		f_d        = '0;
		f_d.cmd    = cmd;
		f_d.az     = a_zero;
		f_d.bz     = b_zero;
		f_d.a      = a_log;
		f_d.b      = b_log;
		f_d.a_gt_b = a_log > b_log;
		f_d.a_eq_b = a_log == b_log;
		f_d.m      = f_d.a_gt_b ? a_log : b_log;
		// |a - b| never exceeds 2^32 - 1
		f_d.d      = f_d.a_gt_b ? LOG_W'(a_log - b_log) : LOG_W'(b_log - a_log);
		f_d.sum    = {a_log[LOG_W-1], a_log} + {b_log[LOG_W-1], b_log};
		f_d.dif    = {a_log[LOG_W-1], a_log} - {b_log[LOG_W-1], b_log};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld) begin
			f_s1 <= f_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/lda_index.sv =====
// stage two: scale the log difference into a correction table index
// depends on lda_pkg
`default_nettype none

module lda_index
	import lda_pkg::*;
#(
	parameter int FRAC_BITS     = 16,
	parameter int TABLE_ENTRIES = 1024,
	parameter int IW            = $clog2(TABLE_ENTRIES)
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   vld_s1,
	input  wire front_t f_s1,
	output logic        vld_s2,
	output front_t      f_s2,
	output logic        in_rng_s2,
	output logic [IW-1:0] idx_s2
);

	localparam int DW = FRAC_BITS + 4;
	localparam int TW = $clog2(TABLE_ENTRIES + 1);

	logic [DW+TW-1:0] prod;
	logic             in_rng;

	// d below 16.0 uses the table, otherwise the correction is zero
	assign in_rng = f_s1.d[LOG_W-1:DW] == '0;
	assign prod   = {{TW{1'b0}}, f_s1.d[DW-1:0]} * (DW+TW)'(TABLE_ENTRIES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			f_s2      <= f_s1;
			in_rng_s2 <= in_rng;
			idx_s2    <= prod[DW +: IW];
		end
	end

endmodule

`default_nettype wire

// ===== src/lda_corr.sv =====
// stage three: read the gaussian log correction for add or subtract
// depends on lda_pkg; tables are built at elaboration
`default_nettype none

module lda_corr
	import lda_pkg::*;
#(
	parameter int FRAC_BITS     = 16,
	parameter int TABLE_ENTRIES = 1024,
	parameter int IW            = $clog2(TABLE_ENTRIES)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          vld_s2,
	input  wire front_t        f_s2,
	input  wire logic          in_rng_s2,
	input  wire logic [IW-1:0] idx_s2,
	output logic               vld_s3,
	output front_t             f_s3,
	output logic signed [LOG_W-1:0] corr_s3
);

	typedef logic signed [LOG_W-1:0] rom_t [TABLE_ENTRIES];

	// entry i at d = (2i+1)*8/entries: ln(1+exp(-d)) or ln(1-exp(-d))
	function automatic rom_t build_rom(input logic sub);
		rom_t t;
		logic [63:0] e1;
		logic [63:0] ln2;
		logic [63:0] dq;
		logic [63:0] y;
		logic [63:0] w;
		logic signed [63:0] v;
		e1  = exp_neg_frac(Q30_ONE);
		ln2 = twice_atanh(Q30_ONE / 3);
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			dq = udiv64((64'(2 * i + 1)) << 33, 64'(TABLE_ENTRIES));
			y  = exp_neg(dq, e1);
			if (sub)
				w = (y >= Q30_ONE) ? 64'd1 : Q30_ONE - y;
			else
				w = Q30_ONE + y;
			v    = to_frac(ln_q30(w, ln2), FRAC_BITS);
			t[i] = v[LOG_W-1:0];
		end
		return t;
	endfunction

	localparam rom_t ROM_ADD = build_rom(1'b0);
	localparam rom_t ROM_SUB = build_rom(1'b1);

	logic signed [LOG_W-1:0] corr;

	always_comb begin
		if (!in_rng_s2)
			corr = '0;
		else if (f_s2.cmd == CMD_SUB)
			corr = ROM_SUB[idx_s2];
		else
			corr = ROM_ADD[idx_s2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			f_s3    <= f_s2;
			corr_s3 <= corr;
		end
	end

endmodule

`default_nettype wire

// ===== src/lda_back.sv =====
// stage four: final add, saturation and the zero and error cases
// depends on lda_pkg
`default_nettype none

module lda_back
	import lda_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    vld_s3,
	input  wire front_t                  f_s3,
	input  wire logic signed [LOG_W-1:0] corr_s3,
	output logic                         vld_s4,
	output logic signed [LOG_W-1:0]      r_s4,
	output logic                         rz_s4,
	output status_t                      st_s4
);

	logic signed [LOG_W+1:0] v;
	logic signed [LOG_W-1:0] vsat;
	logic                    ovf;
	logic signed [LOG_W-1:0] r;
	logic                    rz;
	status_t                 st;

	always_comb begin
		case (f_s3.cmd)
			CMD_ADD, CMD_SUB: v = {{2{f_s3.m[LOG_W-1]}}, f_s3.m}
				+ {{2{corr_s3[LOG_W-1]}}, corr_s3};
			CMD_MUL: v = {f_s3.sum[LOG_W], f_s3.sum};
			CMD_DIV: v = {f_s3.dif[LOG_W], f_s3.dif};
			default: v = '0;
		endcase
	end

	always_comb begin
		ovf  = 1'b1;
		if (v > $signed({{2{LOG_MAX[LOG_W-1]}}, LOG_MAX}))
			vsat = LOG_MAX;
		else if (v < $signed({{2{LOG_MIN[LOG_W-1]}}, LOG_MIN}))
			vsat = LOG_MIN;
		else begin
			vsat = v[LOG_W-1:0];
			ovf  = 1'b0;
		end
	end

	always_comb begin
		r  = vsat;
		rz = 1'b0;
		st = ovf ? ST_SAT : ST_OK;
		case (f_s3.cmd)
			CMD_ADD: begin
				if (f_s3.az) begin
					r  = f_s3.b;
					rz = f_s3.bz;
					st = ST_OK;
				end else if (f_s3.bz) begin
					r  = f_s3.a;
					st = ST_OK;
				end
			end
			CMD_SUB: begin
				if (f_s3.bz) begin
					r  = f_s3.a;
					rz = f_s3.az;
					st = ST_OK;
				end else if (f_s3.az || (!f_s3.a_gt_b && !f_s3.a_eq_b)) begin
					rz = 1'b1;
					st = ST_SUB_BIG;
				end else if (f_s3.a_eq_b) begin
					rz = 1'b1;
					st = ST_OK;
				end
			end
			CMD_MUL: begin
				if (f_s3.az || f_s3.bz) begin
					rz = 1'b1;
					st = ST_OK;
				end
			end
			CMD_DIV: begin
				if (f_s3.bz) begin
					r  = LOG_MAX;
					st = ST_DIV_Z;
				end else if (f_s3.az) begin
					rz = 1'b1;
					st = ST_OK;
				end
			end
			default: begin
				rz = 1'b1;
			end
		endcase
		if (rz)
			r = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s3) begin
			r_s4  <= r;
			rz_s4 <= rz;
			st_s4 <= st;
		end
	end

endmodule

`default_nettype wire

// ===== src/log_domain_arith_unit.sv =====
// top level of the log-domain arithmetic unit: four register stages
// depends on lda_pkg, lda_front, lda_index, lda_corr and lda_back
`default_nettype none

// usage
// - numbers are natural logs in signed fixed point (FRAC_BITS fraction bits)
//   with a separate zero flag standing for a log of minus infinity
// - command beat: drive cmd, a_log, a_zero, b_log, b_zero and raise start;
//   the beat is taken at the clock edge where start is high and busy is low
// - busy is held low: a beat may be issued in every cycle
// - result beat: r_log, r_zero and status are shown for exactly one cycle
//   with done high, once the beat has passed through the stages listed below
// - throughput is one beat per cycle; the stages are compare and subtract,
//   table index scaling (one constant multiply), correction table read,
//   and the final add with saturation
// - results leave in issue order; the receiver cannot hold them off, so no
//   stall path exists and nothing backs up
// - status: ok, subtrahend larger, divide by zero, or saturated
// - reset clears the stage valid bits only; the correction tables are
//   constant logic, so the unit is ready as soon as reset is released
module log_domain_arith_unit
	import lda_pkg::*;
#(
	parameter int FRAC_BITS     = 16,
	parameter int TABLE_ENTRIES = 1024
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [1:0]              cmd,
	input  wire logic signed [LOG_W-1:0] a_log,
	input  wire logic                    a_zero,
	input  wire logic signed [LOG_W-1:0] b_log,
	input  wire logic                    b_zero,
	output logic                         done,
	output logic signed [LOG_W-1:0]      r_log,
	output logic                         r_zero,
	output logic [1:0]                   status
);

	localparam int IW = $clog2(TABLE_ENTRIES);

	// stage valids and carried operands
	logic            in_vld;
	logic            vld_s1;
	logic            vld_s2;
	logic            vld_s3;
	logic            vld_s4;
	front_t          f_s1;
	front_t          f_s2;
	front_t          f_s3;
	logic            in_rng_s2;
	logic [IW-1:0]   idx_s2;
	logic signed [LOG_W-1:0] corr_s3;
	logic signed [LOG_W-1:0] r_s4;
	logic            rz_s4;
	status_t         st_s4;

	// fully pipelined, never refuses a beat
	assign busy   = 1'b0;
	assign in_vld = start && !busy;

	// compare, |a-b|, max, sum and difference
	lda_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (in_vld),
		.cmd    (cmd_t'(cmd)),
		.a_log  (a_log),
		.a_zero (a_zero),
		.b_log  (b_log),
		.b_zero (b_zero),
		.vld_s1 (vld_s1),
		.f_s1   (f_s1)
	);

	// difference scaled to a table index
	lda_index #(
		.FRAC_BITS     (FRAC_BITS),
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.IW            (IW)
	) u_index (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld_s1    (vld_s1),
		.f_s1      (f_s1),
		.vld_s2    (vld_s2),
		.f_s2      (f_s2),
		.in_rng_s2 (in_rng_s2),
		.idx_s2    (idx_s2)
	);

	// add or subtract correction from the constant tables
	lda_corr #(
		.FRAC_BITS     (FRAC_BITS),
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.IW            (IW)
	) u_corr (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld_s2    (vld_s2),
		.f_s2      (f_s2),
		.in_rng_s2 (in_rng_s2),
		.idx_s2    (idx_s2),
		.vld_s3    (vld_s3),
		.f_s3      (f_s3),
		.corr_s3   (corr_s3)
	);

	// final sum, saturation and special cases; registered result beat
	lda_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s3  (vld_s3),
		.f_s3    (f_s3),
		.corr_s3 (corr_s3),
		.vld_s4  (vld_s4),
		.r_s4    (r_s4),
		.rz_s4   (rz_s4),
		.st_s4   (st_s4)
	);

	assign done   = vld_s4;
	assign r_log  = r_s4;
	assign r_zero = rz_s4;
	assign status = st_s4;

endmodule

`default_nettype wire
